[hdl/ssbw_pkg.sv]
// Package for the swept sphere box wall hit block.
// Widths, wall codes, pipeline depths and the structs that pass between stages.
// No dependencies.
package ssbw_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int RAD_W    = COORD_W - 1;
    localparam int NUM_W    = COORD_W + 2;
    localparam int DEN_W    = COORD_W + 1;
    localparam int Q_W      = COORD_W - 1;
    localparam int INT_W    = Q_W - FRAC_W;
    localparam int AXES     = 3;
    localparam int N_WALL   = 5;
    localparam int AX_X     = 0;
    localparam int AX_Y     = 1;
    localparam int AX_Z     = 2;

    localparam int DIV_SPS  = 2;
    localparam int DIV_STG  = (Q_W + DIV_SPS - 1) / DIV_SPS;
    localparam int PREP_STG = 3;
    localparam int DIV_PIPE = DIV_STG + 1;
    localparam int PICK_STG = 2;
    localparam int CON_STG  = 5;
    localparam int NST      = PREP_STG + DIV_PIPE + PICK_STG + CON_STG;

    localparam int LO_W     = DEN_W / 2;
    localparam int HI_W     = DEN_W - LO_W;
    localparam int PROD_W   = DEN_W + COORD_W;
    localparam int P_W      = PROD_W - FRAC_W;
    localparam int V_W      = P_W + 2;

    localparam int IN_BITS     = 6 * COORD_W + RAD_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + 4 * COORD_W + 3;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam logic CFG_XLEN = 1'b0;
    localparam logic CFG_ZLEN = 1'b1;

    localparam logic [COORD_W-1:0] T_ONE = COORD_W'(1) << FRAC_W;
    localparam logic [COORD_W-1:0] SMAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SMIN  = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        WALL_FLOOR = 3'd0,
        WALL_XMIN  = 3'd1,
        WALL_ZMIN  = 3'd2,
        WALL_XMAX  = 3'd3,
        WALL_ZMAX  = 3'd4
    } t_wall;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] s;
        logic [AXES-1:0][DEN_W-1:0]   d;
        logic [RAD_W-1:0]             r;
    } t_side;

    typedef struct packed {
        logic             cand;
        logic             neg;
        logic             sat;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] dn;
        logic [Q_W-1:0]   low;
    } t_dlane;

    typedef struct packed {
        logic               hit;
        t_wall              code;
        logic [COORD_W-1:0] t;
    } t_best;

    function automatic int wall_axis(input int w);
        int a;
        case (w)
            0:       a = AX_Y;
            1, 3:    a = AX_X;
            default: a = AX_Z;
        endcase
        return a;
    endfunction

endpackage

[hdl/ssbw_prep.sv]
// Front stages: differences, wall tests, numerator magnitudes and divider set-up.
// Depends on ssbw_pkg.
module ssbw_prep (
    input  logic                                   i_clk,
    input  logic [ssbw_pkg::PREP_STG-1:0]          i_ce,
    input  logic [2:0][ssbw_pkg::COORD_W-1:0]      i_s,
    input  logic [2:0][ssbw_pkg::COORD_W-1:0]      i_e,
    input  logic [ssbw_pkg::RAD_W-1:0]             i_r,
    input  logic [ssbw_pkg::RAD_W-1:0]             i_xl,
    input  logic [ssbw_pkg::RAD_W-1:0]             i_zl,
    output ssbw_pkg::t_side                        o_side,
    output ssbw_pkg::t_dlane [ssbw_pkg::N_WALL-1:0] o_lane
);
    import ssbw_pkg::*;

    logic signed [NUM_W-1:0] n_num  [N_WALL];
    logic [N_WALL-1:0]       n_cand;
    t_side                   n_side;
    logic signed [NUM_W-1:0] se     [AXES];
    logic signed [NUM_W-1:0] ee     [AXES];
    logic signed [NUM_W-1:0] rr, xl, zl;

    logic signed [NUM_W-1:0] r0_num [N_WALL];
    logic [N_WALL-1:0]       r0_cand;
    t_side                   r0_side;

    logic [NUM_W-1:0]        r1_n    [N_WALL];
    logic [DEN_W-1:0]        r1_dn   [N_WALL];
    logic [N_WALL-1:0]       r1_neg, r1_cand;
    t_side                   r1_side;

    always_comb begin
        rr = $signed(NUM_W'(i_r));
        xl = $signed(NUM_W'(i_xl));
        zl = $signed(NUM_W'(i_zl));
        for (int a = 0; a < AXES; a++) begin
            se[a] = NUM_W'($signed(i_s[a]));
            ee[a] = NUM_W'($signed(i_e[a]));
            n_side.s[a] = i_s[a];
            n_side.d[a] = DEN_W'(ee[a] - se[a]);
        end
        n_side.r = i_r;
        n_num[0] = rr - se[AX_Y];
        n_num[1] = rr - se[AX_X];
        n_num[2] = rr - se[AX_Z];
        n_num[3] = xl - rr - se[AX_X];
        n_num[4] = zl - rr - se[AX_Z];
        n_cand[0] = ((ee[AX_Y] - rr) <= 0) && (n_side.d[AX_Y] != '0);
        n_cand[1] = ((ee[AX_X] - rr) <= 0) && (n_side.d[AX_X] != '0);
        n_cand[2] = ((ee[AX_Z] - rr) <= 0) && (n_side.d[AX_Z] != '0);
        n_cand[3] = ((ee[AX_X] + rr) >= xl) && (n_side.d[AX_X] != '0);
        n_cand[4] = ((ee[AX_Z] + rr) >= zl) && (n_side.d[AX_Z] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r0_num  <= n_num;
            r0_cand <= n_cand;
            r0_side <= n_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[1]) begin
            for (int w = 0; w < N_WALL; w++) begin
                r1_n[w]  <= r0_num[w][NUM_W-1] ? NUM_W'(-r0_num[w]) : NUM_W'(r0_num[w]);
                r1_dn[w] <= r0_side.d[wall_axis(w)][DEN_W-1] ?
                            DEN_W'(-$signed(r0_side.d[wall_axis(w)])) : r0_side.d[wall_axis(w)];
                r1_neg[w] <= r0_num[w][NUM_W-1] ^ r0_side.d[wall_axis(w)][DEN_W-1];
            end
            r1_cand <= r0_cand;
            r1_side <= r0_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[2]) begin
            for (int w = 0; w < N_WALL; w++) begin
                o_lane[w].cand <= r1_cand[w];
                o_lane[w].neg  <= r1_neg[w];
                o_lane[w].sat  <= (DEN_W+INT_W)'(r1_n[w]) >= {r1_dn[w], {INT_W{1'b0}}};
                o_lane[w].rem  <= DEN_W'(r1_n[w] >> INT_W);
                o_lane[w].dn   <= r1_dn[w];
                o_lane[w].low  <= {r1_n[w][INT_W-1:0], {FRAC_W{1'b0}}};
            end
            o_side <= r1_side;
        end
    end

endmodule

[hdl/ssbw_div.sv]
// Pipelined restoring dividers, one lane per wall, and the sign and saturation stage.
// Depends on ssbw_pkg.
module ssbw_div (
    input  logic                                    i_clk,
    input  logic [ssbw_pkg::DIV_PIPE-1:0]           i_ce,
    input  ssbw_pkg::t_dlane [ssbw_pkg::N_WALL-1:0] i_lane,
    input  ssbw_pkg::t_side                         i_side,
    output logic [ssbw_pkg::N_WALL-1:0][ssbw_pkg::COORD_W-1:0] o_t,
    output logic [ssbw_pkg::N_WALL-1:0]             o_cand,
    output ssbw_pkg::t_side                         o_side
);
    import ssbw_pkg::*;

    typedef struct packed {
        t_dlane         l;
        logic [Q_W-1:0] q;
    } t_dq;

    t_dq   r_q    [DIV_STG][N_WALL];
    t_side r_side [DIV_STG];

    for (genvar g = 0; g < DIV_STG; g++) begin : g_stg
        t_dq src [N_WALL];
        t_dq nxt [N_WALL];

        if (g == 0) begin : g_first
            always_comb begin
                for (int w = 0; w < N_WALL; w++) begin
                    src[w].l = i_lane[w];
                    src[w].q = '0;
                end
            end
        end else begin : g_rest
            always_comb begin
                for (int w = 0; w < N_WALL; w++) src[w] = r_q[g-1][w];
            end
        end

        always_comb begin
            logic [DEN_W:0] trial;
            logic           qb;
            for (int w = 0; w < N_WALL; w++) begin
                nxt[w] = src[w];
                for (int j = 0; j < DIV_SPS; j++) begin
                    if (g * DIV_SPS + j < Q_W) begin
                        trial = {nxt[w].l.rem, nxt[w].l.low[Q_W-1]};
                        nxt[w].l.low = nxt[w].l.low << 1;
                        qb = trial >= {1'b0, nxt[w].l.dn};
                        if (qb) nxt[w].l.rem = DEN_W'(trial - {1'b0, nxt[w].l.dn});
                        else    nxt[w].l.rem = trial[DEN_W-1:0];
                        nxt[w].q = {nxt[w].q[Q_W-2:0], qb};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce[g]) begin
                r_q[g]    <= nxt;
                r_side[g] <= (g == 0) ? i_side : r_side[(g == 0) ? 0 : g-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[DIV_STG]) begin
            for (int w = 0; w < N_WALL; w++) begin
                if (r_q[DIV_STG-1][w].l.sat)
                    o_t[w] <= r_q[DIV_STG-1][w].l.neg ? SMIN : SMAX;
                else if (r_q[DIV_STG-1][w].l.neg)
                    o_t[w] <= COORD_W'(-{1'b0, r_q[DIV_STG-1][w].q});
                else
                    o_t[w] <= {1'b0, r_q[DIV_STG-1][w].q};
                o_cand[w] <= r_q[DIV_STG-1][w].l.cand;
            end
            o_side <= r_side[DIV_STG-1];
        end
    end

endmodule

[hdl/ssbw_pick.sv]
// Two-stage tournament that picks the winning wall, earliest wall on a tie.
// Depends on ssbw_pkg.
module ssbw_pick (
    input  logic                                               i_clk,
    input  logic [ssbw_pkg::PICK_STG-1:0]                      i_ce,
    input  logic [ssbw_pkg::N_WALL-1:0][ssbw_pkg::COORD_W-1:0] i_t,
    input  logic [ssbw_pkg::N_WALL-1:0]                        i_cand,
    input  ssbw_pkg::t_side                                    i_side,
    output ssbw_pkg::t_best                                    o_best,
    output ssbw_pkg::t_side                                    o_side
);
    import ssbw_pkg::*;

    typedef struct packed {
        logic  pres;
        t_best b;
    } t_ent;

    function automatic t_ent pick2(input t_ent a, input t_ent c);
        t_ent m;
        if (c.pres && (!a.pres || ($signed(c.b.t) < $signed(a.b.t)))) m = c;
        else m = a;
        m.pres = a.pres | c.pres;
        return m;
    endfunction

    t_ent e [N_WALL];
    t_ent r_m1, r_m2, r_zmax, fin;
    t_side r_side;

    always_comb begin
        e[0].pres   = 1'b1;
        e[0].b.hit  = i_cand[0];
        e[0].b.code = WALL_FLOOR;
        e[0].b.t    = i_cand[0] ? i_t[0] : T_ONE;
        for (int w = 1; w < N_WALL; w++) begin
            e[w].pres  = i_cand[w];
            e[w].b.hit = 1'b1;
            e[w].b.t   = i_t[w];
        end
        e[1].b.code = WALL_XMIN;
        e[2].b.code = WALL_ZMIN;
        e[3].b.code = WALL_XMAX;
        e[4].b.code = WALL_ZMAX;
        fin = pick2(pick2(r_m1, r_m2), r_zmax);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r_m1   <= pick2(e[0], e[1]);
            r_m2   <= pick2(e[2], e[3]);
            r_zmax <= e[4];
            r_side <= i_side;
        end
        if (i_ce[1]) begin
            o_best <= fin.b;
            o_side <= r_side;
        end
    end

endmodule

[hdl/ssbw_contact.sv]
// Contact point: split multiply of d by t, scale, add start and signed radius offset, saturate; zero on a miss.
// Depends on ssbw_pkg.
module ssbw_contact (
    input  logic                                          i_clk,
    input  logic [ssbw_pkg::CON_STG-1:0]                  i_ce,
    input  ssbw_pkg::t_best                               i_best,
    input  ssbw_pkg::t_side                               i_side,
    output ssbw_pkg::t_best                               o_best,
    output logic [ssbw_pkg::AXES-1:0][ssbw_pkg::COORD_W-1:0] o_c
);
    import ssbw_pkg::*;

    t_best r_best [CON_STG-1];
    logic [AXES-1:0][COORD_W-1:0] r_s [CON_STG-1];
    logic [RAD_W-1:0] r_r [CON_STG-2];

    logic [DEN_W-1:0]           r0_a   [AXES];
    logic [COORD_W-1:0]         r0_b;
    logic [AXES-1:0]            r0_neg;
    logic [AXES-1:0]            r1_neg, r2_neg;
    logic [LO_W+COORD_W-1:0]    r1_lo  [AXES];
    logic [HI_W+COORD_W-1:0]    r1_hi  [AXES];
    logic [P_W-1:0]             r2_sh  [AXES];
    logic signed [V_W-1:0]      r3_p   [AXES];
    logic signed [V_W-1:0]      r3_adj [AXES];

    logic [PROD_W-1:0]          n_mag  [AXES];
    logic signed [V_W-1:0]      n_v    [AXES];
    logic signed [V_W-1:0]      rad;
    int                         ax;
    logic                       pos;

    always_comb begin
        case (r_best[2].code)
            WALL_FLOOR: begin ax = AX_Y; pos = 1'b0; end
            WALL_XMIN:  begin ax = AX_X; pos = 1'b0; end
            WALL_ZMIN:  begin ax = AX_Z; pos = 1'b0; end
            WALL_XMAX:  begin ax = AX_X; pos = 1'b1; end
            default:    begin ax = AX_Z; pos = 1'b1; end
        endcase
        rad = $signed(V_W'(r_r[2]));
        for (int i = 0; i < AXES; i++) begin
            n_mag[i] = (PROD_W'(r1_hi[i]) << LO_W) + PROD_W'(r1_lo[i]);
            n_v[i]   = V_W'($signed(r_s[3][i])) + r3_p[i] + r3_adj[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            for (int i = 0; i < AXES; i++) begin
                r0_a[i] <= i_side.d[i][DEN_W-1] ?
                           DEN_W'(-$signed(i_side.d[i])) : i_side.d[i];
                r0_neg[i] <= i_side.d[i][DEN_W-1] ^ i_best.t[COORD_W-1];
            end
            r0_b <= i_best.t[COORD_W-1] ? COORD_W'(-$signed(i_best.t)) : i_best.t;
            r_best[0] <= i_best;
            r_s[0]    <= i_side.s;
            r_r[0]    <= i_side.r;
        end
        if (i_ce[1]) begin
            for (int i = 0; i < AXES; i++) begin
                r1_lo[i] <= r0_a[i][LO_W-1:0] * r0_b;
                r1_hi[i] <= r0_a[i][DEN_W-1:LO_W] * r0_b;
            end
            r1_neg    <= r0_neg;
            r_best[1] <= r_best[0];
            r_s[1]    <= r_s[0];
            r_r[1]    <= r_r[0];
        end
        if (i_ce[2]) begin
            for (int i = 0; i < AXES; i++) r2_sh[i] <= n_mag[i][PROD_W-1:FRAC_W];
            r2_neg    <= r1_neg;
            r_best[2] <= r_best[1];
            r_s[2]    <= r_s[1];
            r_r[2]    <= r_r[1];
        end
        if (i_ce[3]) begin
            for (int i = 0; i < AXES; i++) begin
                r3_p[i] <= r2_neg[i] ? -$signed(V_W'(r2_sh[i])) : $signed(V_W'(r2_sh[i]));
                if (i == ax) r3_adj[i] <= pos ? rad : -rad;
                else         r3_adj[i] <= '0;
            end
            r_best[3] <= r_best[2];
            r_s[3]    <= r_s[2];
        end
        if (i_ce[4]) begin
            for (int i = 0; i < AXES; i++) begin
                if (!r_best[3].hit)
                    o_c[i] <= '0;
                else if (n_v[i] > $signed(V_W'($signed(SMAX))))
                    o_c[i] <= SMAX;
                else if (n_v[i] < $signed(V_W'($signed(SMIN))))
                    o_c[i] <= SMIN;
                else
                    o_c[i] <= n_v[i][COORD_W-1:0];
            end
            o_best <= r_best[3];
        end
    end

endmodule

[hdl/swept_sphere_box_wall_hit_top.sv]
// Top level of the swept sphere box wall hit block: stream ports, register port, flow control.
// Depends on ssbw_pkg, ssbw_prep, ssbw_div, ssbw_pick and ssbw_contact.
//
// Takes one sphere move per clock unless back-pressure has filled the pipeline, and returns
// one result per move, in order. The pipeline holds the five 31-bit restoring dividers,
// two quotient bits per stage, plus the set-up, selection and contact multiply stages.
// Each stage holds its own valid bit, so a stalled output only stops the stages behind
// it until they fill. Write box_x_length at byte address 0 and box_z_length at 4 while
// no move is in flight.
module swept_sphere_box_wall_hit_top
    import ssbw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, radius, zero fill
    input  logic [IN_TDATA_W-1:0]    i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // hit, hit_fraction, contact_x, contact_y, contact_z, wall_code, zero fill
    output logic [OUT_TDATA_W-1:0]   o_m_tdata,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [CFG_AW-1:0]        i_paddr,
    input  logic [CFG_DW-1:0]        i_pwdata,
    output logic [CFG_DW-1:0]        o_prdata,
    output logic                     o_pready
);

    logic [RAD_W-1:0]             r_xl, r_zl;
    logic [NST-1:0]               r_v, n_v, ce;
    logic [AXES-1:0][COORD_W-1:0] s_in, e_in;
    t_side                        p_side, d_side, k_side;
    t_dlane [N_WALL-1:0]          p_lane;
    logic [N_WALL-1:0][COORD_W-1:0] d_t;
    logic [N_WALL-1:0]            d_cand;
    t_best                        k_best, c_best;
    logic [AXES-1:0][COORD_W-1:0] c_pt;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xl <= '0;
            r_zl <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (i_paddr[CFG_AW-1])
                CFG_XLEN: r_xl <= i_pwdata[RAD_W-1:0];
                CFG_ZLEN: r_zl <= i_pwdata[RAD_W-1:0];
                default:  r_xl <= r_xl;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[CFG_AW-1])
            CFG_XLEN: o_prdata = CFG_DW'(r_xl);
            CFG_ZLEN: o_prdata = CFG_DW'(r_zl);
            default:  o_prdata = '0;
        endcase
    end

    always_comb begin
        ce[NST-1] = !r_v[NST-1] || i_m_tready;
        for (int k = NST - 2; k >= 0; k--) ce[k] = !r_v[k] || ce[k+1];
        for (int k = 0; k < NST; k++) begin
            if (ce[k]) n_v[k] = (k == 0) ? i_s_tvalid : r_v[(k == 0) ? 0 : k-1];
            else       n_v[k] = r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= n_v;
    end

    assign o_s_tready = ce[0];
    assign o_m_tvalid = r_v[NST-1];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            s_in[a] = i_s_tdata[a*COORD_W +: COORD_W];
            e_in[a] = i_s_tdata[(AXES+a)*COORD_W +: COORD_W];
        end
    end

    ssbw_prep u_prep (
        .i_clk  (i_clk),
        .i_ce   (ce[PREP_STG-1:0]),
        .i_s    (s_in),
        .i_e    (e_in),
        .i_r    (i_s_tdata[2*AXES*COORD_W +: RAD_W]),
        .i_xl   (r_xl),
        .i_zl   (r_zl),
        .o_side (p_side),
        .o_lane (p_lane)
    );

    ssbw_div u_div (
        .i_clk  (i_clk),
        .i_ce   (ce[PREP_STG +: DIV_PIPE]),
        .i_lane (p_lane),
        .i_side (p_side),
        .o_t    (d_t),
        .o_cand (d_cand),
        .o_side (d_side)
    );

    ssbw_pick u_pick (
        .i_clk  (i_clk),
        .i_ce   (ce[PREP_STG+DIV_PIPE +: PICK_STG]),
        .i_t    (d_t),
        .i_cand (d_cand),
        .i_side (d_side),
        .o_best (k_best),
        .o_side (k_side)
    );

    ssbw_contact u_contact (
        .i_clk  (i_clk),
        .i_ce   (ce[PREP_STG+DIV_PIPE+PICK_STG +: CON_STG]),
        .i_best (k_best),
        .i_side (k_side),
        .o_best (c_best),
        .o_c    (c_pt)
    );

    assign o_m_tdata = OUT_TDATA_W'({c_best.code, c_pt[AX_Z], c_pt[AX_Y], c_pt[AX_X],
                                     c_best.t, c_best.hit});

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input blocked while the pipeline has room");

    a_no_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !c_best.hit) |->
        (c_best.t == T_ONE && c_best.code == WALL_FLOOR && c_pt == '0))
        else $error("miss result carries a fraction, point or wall");

    a_accept_reaches_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v[0])
        else $error("accepted word lost at the first stage");

endmodule

[tb/sv/swept_sphere_box_wall_hit_top_tb.sv]
// Testbench for swept_sphere_box_wall_hit_top: sphere moves against the walls of an open box.
// A built-in predictor works out each expected word; results are checked in order.
// Depends on ssbw_pkg and the block's RTL.
module swept_sphere_box_wall_hit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssbw_pkg::*;

    localparam logic [CFG_AW-1:0] ADDR_XLEN = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_ZLEN = 3'd4;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint QONE = 64'sd65536;
    localparam longint CLAMP = 64'sd1 << 60;

    typedef struct packed {
        logic [RAD_W-1:0]   radius;
        logic [COORD_W-1:0] ez, ey, ex, sz, sy, sx;
    } t_move;

    typedef struct packed {
        t_wall              wall;
        logic [COORD_W-1:0] cz, cy, cx;
        logic [COORD_W-1:0] frac;
        logic               hit;
    } t_hit;

    logic i_clk = 0, i_rst_n = 0;
    logic i_s_tvalid = 0, i_m_tready = 0;
    logic [IN_TDATA_W-1:0] i_s_tdata = '0;
    logic o_s_tready, o_m_tvalid, o_pready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic i_psel = 0, i_penable = 0, i_pwrite = 0;
    logic [CFG_AW-1:0] i_paddr = '0;
    logic [CFG_DW-1:0] i_pwdata = '0, o_prdata;

    swept_sphere_box_wall_hit_top dut (.*);

    always #5 i_clk = ~i_clk;

    longint box_xlen, box_zlen;
    t_hit   hits_due[$];
    int     mismatches = 0;
    bit     free_sink = 0;

    function automatic longint clip(input longint v);
        return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
    endfunction

    function automatic longint frac_div(input longint num, input longint den);
        bit neg;
        longint unsigned n, dn, q, mag;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        dn = den < 0 ? -den : den;
        q = n / dn;
        if (q >= 64'd32768) return neg ? CMIN : CMAX;
        mag = (q << FRAC_W) | (((n % dn) << FRAC_W) / dn);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint scale(input longint d, input longint t);
        logic signed [127:0] p;
        logic [127:0] m;
        p = 128'(d) * 128'(t);
        m = p < 0 ? -p : p;
        m = m >> FRAC_W;
        if (m > 128'(CLAMP)) m = 128'(CLAMP);
        return p < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic t_hit predict_hit(input t_move mv);
        longint s[3], e[3], d[3], r, t, tw, v;
        int axis, dir;
        t_hit h;
        s[0] = longint'($signed(mv.sx)); s[1] = longint'($signed(mv.sy));
        s[2] = longint'($signed(mv.sz)); e[0] = longint'($signed(mv.ex));
        e[1] = longint'($signed(mv.ey)); e[2] = longint'($signed(mv.ez));
        r = longint'(mv.radius);
        for (int i = 0; i < 3; i++) d[i] = e[i] - s[i];
        t = QONE;
        h = '0;
        h.wall = WALL_FLOOR;
        if (e[1] - r <= 0 && d[1] != 0) begin
            t = frac_div(r - s[1], d[1]);
            h.hit = 1;
        end
        if (e[0] - r <= 0 && d[0] != 0) begin
            tw = frac_div(r - s[0], d[0]);
            if (tw < t) begin t = tw; h.hit = 1; h.wall = WALL_XMIN; end
        end
        if (e[2] - r <= 0 && d[2] != 0) begin
            tw = frac_div(r - s[2], d[2]);
            if (tw < t) begin t = tw; h.hit = 1; h.wall = WALL_ZMIN; end
        end
        if (e[0] + r >= box_xlen && d[0] != 0) begin
            tw = frac_div(box_xlen - r - s[0], d[0]);
            if (tw < t) begin t = tw; h.hit = 1; h.wall = WALL_XMAX; end
        end
        if (e[2] + r >= box_zlen && d[2] != 0) begin
            tw = frac_div(box_zlen - r - s[2], d[2]);
            if (tw < t) begin t = tw; h.hit = 1; h.wall = WALL_ZMAX; end
        end
        h.frac = t[31:0];
        if (h.hit) begin
            axis = wall_axis(int'(h.wall));
            dir = (h.wall == WALL_XMAX || h.wall == WALL_ZMAX) ? 1 : -1;
            for (int i = 0; i < 3; i++) begin
                v = s[i] + scale(d[i], t);
                if (i == axis) v += dir * r;
                v = clip(v);
                if (i == 0) h.cx = v[31:0];
                else if (i == 1) h.cy = v[31:0];
                else h.cz = v[31:0];
            end
        end
        return h;
    endfunction

    task automatic idle(input int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic send_move(input t_move mv);
        int n;
        n = $urandom_range(0, 3);
        if (n > 0) begin
            i_s_tvalid <= 0;
            idle(n);
        end
        i_s_tdata <= IN_TDATA_W'(mv);
        i_s_tvalid <= 1;
        do @(posedge i_clk); while (!o_s_tready);
        hits_due.push_back(predict_hit(mv));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (hits_due.size() != 0) @(negedge i_clk);
        idle(40);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] val);
        @(negedge i_clk);
        i_psel <= 1; i_pwrite <= 1; i_paddr <= addr; i_pwdata <= val;
        @(negedge i_clk);
        i_penable <= 1;
        do @(posedge i_clk); while (!o_pready);
        if (addr == ADDR_XLEN) box_xlen = longint'(val[30:0]);
        else box_zlen = longint'(val[30:0]);
        @(negedge i_clk);
        i_psel <= 0; i_penable <= 0; i_pwrite <= 0;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (8 << 16));
        endcase
    endfunction

    function automatic t_move rand_move();
        t_move mv;
        mv.sx = pick_coord(); mv.sy = pick_coord(); mv.sz = pick_coord();
        mv.ex = pick_coord(); mv.ey = pick_coord(); mv.ez = pick_coord();
        if ($urandom_range(0, 7) == 0) mv.ex = mv.sx;
        if ($urandom_range(0, 7) == 0) mv.ey = mv.sy;
        if ($urandom_range(0, 7) == 0) mv.ez = mv.sz;
        case ($urandom_range(0, 4))
            0: mv.radius = RAD_W'($urandom());
            1: mv.radius = 0;
            default: mv.radius = RAD_W'($urandom_range(0, 4 << 16));
        endcase
        return mv;
    endfunction

    task automatic test_directed();
        t_move mv;
        write_reg(ADDR_XLEN, 32'd0);
        write_reg(ADDR_ZLEN, 32'd0);
        mv = '0;
        send_move(mv);
        mv = '{radius: 31'h1_0000, sx: 32'h5_0000, sy: 32'h5_0000, sz: 32'h5_0000,
               ex: 32'h5_0000, ey: 32'hfffd_0000, ez: 32'h5_0000};
        send_move(mv);
        mv.radius = '1;
        send_move(mv);
        mv = '{radius: 0, sx: 32'h8000_0000, sy: 32'h7fff_ffff, sz: 32'h8000_0000,
               ex: 32'h7fff_ffff, ey: 32'h8000_0000, ez: 32'h7fff_ffff};
        send_move(mv);
        mv = '{radius: 0, sx: 32'h7fff_ffff, sy: 32'h8000_0000, sz: 32'h7fff_ffff,
               ex: 32'h8000_0000, ey: 32'h7fff_ffff, ez: 32'h8000_0000};
        send_move(mv);
        drain();
        write_reg(ADDR_XLEN, 32'h000a_0000);
        write_reg(ADDR_ZLEN, 32'h000a_0000);
        // walls one by one, then level with another, then start behind wall
        mv = '{radius: 31'h8000, sx: 32'h2_0000, sy: 32'h5_0000, sz: 32'h5_0000,
               ex: 32'hfffe_0000, ey: 32'h5_0000, ez: 32'h5_0000};
        send_move(mv);
        mv.sx = 32'h5_0000; mv.ex = 32'h5_0000; mv.sz = 32'h2_0000; mv.ez = 32'hfffe_0000;
        send_move(mv);
        mv.sz = 32'h5_0000; mv.ez = 32'h5_0000; mv.sx = 32'h8_0000; mv.ex = 32'hc_0000;
        send_move(mv);
        mv.sx = 32'h5_0000; mv.ex = 32'h5_0000; mv.sz = 32'h8_0000; mv.ez = 32'hc_0000;
        send_move(mv);
        mv.sx = 32'h2_0000; mv.ex = 32'hfffe_0000; mv.sz = 32'h2_0000; mv.ez = 32'hfffe_0000;
        send_move(mv);
        mv.sy = 32'hfff0_0000; mv.ey = 32'hfff0_0000;
        send_move(mv);
        mv.sy = 32'h0001_0000; mv.ey = 32'hffff_0000; mv.radius = 0;
        send_move(mv);
        drain();
        write_reg(ADDR_XLEN, 32'hffff_ffff);
        write_reg(ADDR_ZLEN, 32'h7fff_ffff);
        for (int i = 0; i < 8; i++) send_move(rand_move());
        drain();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_move(rand_move());
    endtask

    task automatic test_settings();
        write_reg(ADDR_XLEN, 32'h0014_0000);
        write_reg(ADDR_ZLEN, 32'h001e_0000);
        test_random(250);
        drain();
        write_reg(ADDR_XLEN, $urandom());
        write_reg(ADDR_ZLEN, 32'h0);
        test_random(200);
        drain();
        write_reg(ADDR_XLEN, 32'h0020_0000);
        write_reg(ADDR_ZLEN, 32'h0008_0000);
        free_sink = 1;
        test_random(100);
        free_sink = 0;
        test_random(150);
        drain();
    endtask

    initial begin : sink
        int n;
        forever begin
            n = free_sink ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
                i_m_tready <= 0;
                idle(n);
            end
            i_m_tready <= 1;
            do @(posedge i_clk); while (!(i_rst_n && o_m_tvalid));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_hit got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_hit'(o_m_tdata[$bits(t_hit)-1:0]);
            if (hits_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = hits_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit %0b t %h c %h %h %h w %0d",
                                 want.hit, want.frac, want.cx, want.cy, want.cz, want.wall,
                                 " got hit %0b t %h c %h %h %h w %0d",
                                 got.hit, got.frac, got.cx, got.cy, got.cz, got.wall);
                end
            end
        end
    end

    initial begin
        box_xlen = 0;
        box_zlen = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_settings();
        if (mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
